// ===== hdl/cse_pkg.sv =====
// Shared types, constants and fixed-point helpers of the crescent surface evaluator.
`default_nettype none
package cse_pkg;

  localparam int CordicStagesDef = 16;

  localparam logic signed [15:0] ScaleAReset = 16'sd6144;
  localparam logic signed [15:0] FreqBReset  = 16'sd2048;
  localparam logic signed [15:0] FreqCReset  = 16'sd4096;

  localparam logic [1:0] RegScaleA = 2'd0;
  localparam logic [1:0] RegFreqB  = 2'd1;
  localparam logic [1:0] RegFreqC  = 2'd2;

  localparam longint TwoPiQ25    = 64'sd210828714;
  localparam longint TwoPiQ30    = TwoPiQ25 * 32;
  localparam longint PiQ30       = TwoPiQ30 / 2;
  localparam longint HalfPiQ30   = TwoPiQ30 / 4;
  localparam longint GainQ30     = 64'sd652032874;
  localparam longint FourPiQ30   = 64'sd1367130551;
  localparam longint FourPiQ16   = 64'sd83443;
  localparam longint TwoQ16      = 64'sd131072;

  // rotator word: 34-bit x, y and residual angle, plus the quadrant flip
  typedef struct packed {
    logic signed [33:0] x;
    logic signed [33:0] y;
    logic signed [33:0] z;
    logic               neg;
  } rot_t;

  typedef struct packed {
    logic signed [31:0] dv_z;
    logic signed [31:0] dv_y;
    logic signed [31:0] dv_x;
    logic signed [31:0] du_z;
    logic signed [31:0] du_y;
    logic signed [31:0] du_x;
    logic signed [31:0] pos_z;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_x;
  } result_t;

  function automatic logic signed [31:0] atan_q30(input int idx);
    logic signed [31:0] r;
    case (idx)
      0:  r = 32'sd843314857;
      1:  r = 32'sd497837829;
      2:  r = 32'sd263043837;
      3:  r = 32'sd133525159;
      4:  r = 32'sd67021687;
      5:  r = 32'sd33543516;
      6:  r = 32'sd16775851;
      7:  r = 32'sd8388437;
      8:  r = 32'sd4194283;
      9:  r = 32'sd2097149;
      10: r = 32'sd1048576;
      11: r = 32'sd524288;
      12: r = 32'sd262144;
      13: r = 32'sd131072;
      14: r = 32'sd65536;
      15: r = 32'sd32768;
      16: r = 32'sd16384;
      17: r = 32'sd8192;
      18: r = 32'sd4096;
      19: r = 32'sd2048;
      20: r = 32'sd1024;
      21: r = 32'sd512;
      22: r = 32'sd256;
      23: r = 32'sd128;
      24: r = 32'sd64;
      25: r = 32'sd32;
      26: r = 32'sd16;
      27: r = 32'sd8;
      28: r = 32'sd4;
      29: r = 32'sd2;
      30: r = 32'sd1;
      default: r = 32'sd0;
    endcase
    return r;
  endfunction

  // Q.16 product, round half up
  function automatic logic signed [25:0] qmul_s(input logic signed [23:0] a,
                                                input logic signed [17:0] b);
    logic signed [41:0] p;
    p = a * b + 42'sd32768;
    return p[41:16];
  endfunction

  function automatic logic signed [23:0] qmul_w(input logic signed [19:0] a,
                                                input logic signed [19:0] b);
    logic signed [39:0] p;
    p = a * b + 40'sd32768;
    return p[39:16];
  endfunction

endpackage
`default_nettype wire

// ===== hdl/cse_rot_cell.sv =====
// One CORDIC rotation cell: a fixed shift and arctangent step, registered.
`default_nettype none
module cse_rot_cell #(
  parameter int Shift = 0
) (
  input  wire logic         clk_i,
  input  wire logic         en_i,
  input  wire cse_pkg::rot_t in_i,
  output      cse_pkg::rot_t out_o
);
  localparam logic signed [33:0] Atan = 34'(cse_pkg::atan_q30(Shift));

  cse_pkg::rot_t cell_d, cell_q;

  always_comb begin
    cell_d = in_i;
    if (!in_i.z[33]) begin
      cell_d.x = in_i.x - (in_i.y >>> Shift);
      cell_d.y = in_i.y + (in_i.x >>> Shift);
      cell_d.z = in_i.z - Atan;
    end else begin
      cell_d.x = in_i.x + (in_i.y >>> Shift);
      cell_d.y = in_i.y - (in_i.x >>> Shift);
      cell_d.z = in_i.z + Atan;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) cell_q <= cell_d;
  end

  assign out_o = cell_q;
endmodule
`default_nettype wire

// ===== hdl/cse_sincos_lane.sv =====
// Sine/cosine lane: angle product, mod 2 pi reduction, fold, CORDIC cell row, rounding.
`default_nettype none
module cse_sincos_lane #(
  parameter int CordicStages = cse_pkg::CordicStagesDef
) (
  input  wire logic               clk_i,
  input  wire logic               en_i,
  input  wire logic signed [15:0] factor_i,
  input  wire logic        [15:0] param_i,
  output      logic signed [17:0] sin_o,
  output      logic signed [17:0] cos_o
);
  localparam logic signed [33:0] TwoPi  = 34'(cse_pkg::TwoPiQ25);
  localparam logic signed [35:0] Pi30   = 36'(cse_pkg::PiQ30);
  localparam logic signed [35:0] TwoPi30 = 36'(cse_pkg::TwoPiQ30);
  localparam logic signed [35:0] Half30 = 36'(cse_pkg::HalfPiQ30);

  logic signed [32:0] prod;
  logic signed [33:0] red_q [5];
  logic signed [35:0] z36, z1;
  cse_pkg::rot_t      fold_d, fold_q;
  cse_pkg::rot_t      chain [CordicStages+1];
  logic signed [33:0] xf, yf, xr, yr;
  logic signed [17:0] sin_q, cos_q;

  assign prod = factor_i * $signed({1'b0, param_i});

  always_ff @(posedge clk_i) begin
    if (en_i) red_q[0] <= prod[32] ? 34'(prod) + (TwoPi <<< 4) : 34'(prod);
  end

  // restoring reduction: take off 8, 4, 2 and 1 times 2 pi
  for (genvar k = 0; k < 4; k++) begin : g_red
    localparam logic signed [33:0] Step = TwoPi <<< (3 - k);
    always_ff @(posedge clk_i) begin
      if (en_i) red_q[k+1] <= (red_q[k] >= Step) ? red_q[k] - Step : red_q[k];
    end
  end

  always_comb begin
    z36 = 36'(red_q[4]) <<< 5;
    z1  = (z36 >= Pi30) ? z36 - TwoPi30 : z36;
    fold_d.x   = 34'(cse_pkg::GainQ30);
    fold_d.y   = '0;
    fold_d.neg = 1'b0;
    fold_d.z   = z1[33:0];
    if (z1 > Half30) begin
      fold_d.z   = 34'(z1 - Pi30);
      fold_d.neg = 1'b1;
    end else if (z1 < -Half30) begin
      fold_d.z   = 34'(z1 + Pi30);
      fold_d.neg = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) fold_q <= fold_d;
  end

  assign chain[0] = fold_q;
  for (genvar i = 0; i < CordicStages; i++) begin : g_cell
    cse_rot_cell #(.Shift(i)) u_cell (
      .clk_i (clk_i),
      .en_i  (en_i),
      .in_i  (chain[i]),
      .out_o (chain[i+1])
    );
  end

  always_comb begin
    xf = chain[CordicStages].neg ? -chain[CordicStages].x : chain[CordicStages].x;
    yf = chain[CordicStages].neg ? -chain[CordicStages].y : chain[CordicStages].y;
    xr = (xf + 34'sd8192) >>> 14;
    yr = (yf + 34'sd8192) >>> 14;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cos_q <= xr[17:0];
      sin_q <= yr[17:0];
    end
  end

  assign sin_o = sin_q;
  assign cos_o = cos_q;
endmodule
`default_nettype wire

// ===== hdl/cse_combine.sv =====
// Four-stage product/sum pipeline forming the surface point and both tangents.
`default_nettype none
module cse_combine (
  input  wire logic               clk_i,
  input  wire logic               en_i,
  input  wire logic signed [15:0] scale_a_i,
  input  wire logic signed [15:0] freq_b_i,
  input  wire logic signed [15:0] freq_c_i,
  input  wire logic        [15:0] v_i,
  input  wire logic signed [17:0] sbu_i,
  input  wire logic signed [17:0] cbu_i,
  input  wire logic signed [17:0] sbv_i,
  input  wire logic signed [17:0] cbv_i,
  input  wire logic signed [17:0] scv_i,
  input  wire logic signed [17:0] ccv_i,
  output      cse_pkg::result_t   res_o
);
  logic signed [19:0] a16, b16, c16;
  assign a16 = {scale_a_i, 4'b0};
  assign b16 = {freq_b_i, 4'b0};
  assign c16 = {freq_c_i, 4'b0};

  // stage 1
  logic signed [25:0] p_w, cs_w, cc_w, bcbv_w;
  logic        [47:0] v4_w;
  logic signed [23:0] p_q, cs_q, cc_q, bcbv_q, ac_q, v4_q;
  logic signed [17:0] sbu1_q, scv1_q, ccv1_q;

  assign p_w    = cse_pkg::qmul_s(24'(sbu_i), sbv_i);
  assign cs_w   = cse_pkg::qmul_s(24'(cbu_i), sbv_i);
  assign cc_w   = cse_pkg::qmul_s(24'(cbu_i), cbv_i);
  assign bcbv_w = cse_pkg::qmul_s(24'(b16), cbv_i);
  assign v4_w   = 48'(v_i) * 48'(cse_pkg::FourPiQ30) + 48'(64'sd67108864);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q    <= p_w[23:0];
      cs_q   <= cs_w[23:0];
      cc_q   <= cc_w[23:0];
      bcbv_q <= bcbv_w[23:0];
      ac_q   <= cse_pkg::qmul_w(a16, c16);
      v4_q   <= 24'(v4_w[47:27]);
      sbu1_q <= sbu_i;
      scv1_q <= scv_i;
      ccv1_q <= ccv_i;
    end
  end

  // stage 2
  logic signed [25:0] bcs_w, bp_w, bcb_w, cp_w, bcc_w;
  logic signed [23:0] asin2_q, bcs_q, nbp_q, bcb_q, cp_q, o2_q, o8_q, ac2_q;
  logic signed [17:0] scv2_q, ccv2_q;

  assign bcs_w = cse_pkg::qmul_s(24'(b16), 18'(cs_q));
  assign bp_w  = cse_pkg::qmul_s(24'(b16), 18'(p_q));
  assign bcb_w = cse_pkg::qmul_s(bcbv_q, sbu1_q);
  assign cp_w  = cse_pkg::qmul_s(24'(c16), 18'(p_q));
  assign bcc_w = cse_pkg::qmul_s(24'(b16), 18'(cc_q));

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      asin2_q <= 24'(a16) + p_q;
      bcs_q   <= bcs_w[23:0];
      nbp_q   <= -bp_w[23:0];
      bcb_q   <= bcb_w[23:0];
      cp_q    <= cp_w[23:0];
      o2_q    <= cs_q + v4_q - 24'(cse_pkg::TwoQ16);
      o8_q    <= bcc_w[23:0] + 24'(cse_pkg::FourPiQ16);
      ac2_q   <= ac_q;
      scv2_q  <= scv1_q;
      ccv2_q  <= ccv1_q;
    end
  end

  // stage 3
  logic signed [25:0] o0_q, o1_q, o3_q, o4_q, t1_q, t2_q, t3_q, t4_q, t5_q, t6_q;
  logic signed [23:0] o2b_q, o5_q, o8b_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      o0_q  <= cse_pkg::qmul_s(asin2_q, scv2_q);
      o1_q  <= cse_pkg::qmul_s(asin2_q, ccv2_q);
      o3_q  <= cse_pkg::qmul_s(bcs_q, scv2_q);
      o4_q  <= cse_pkg::qmul_s(bcs_q, ccv2_q);
      t1_q  <= cse_pkg::qmul_s(ac2_q, ccv2_q);
      t2_q  <= cse_pkg::qmul_s(bcb_q, scv2_q);
      t3_q  <= cse_pkg::qmul_s(cp_q, ccv2_q);
      t4_q  <= cse_pkg::qmul_s(bcb_q, ccv2_q);
      t5_q  <= cse_pkg::qmul_s(ac2_q, scv2_q);
      t6_q  <= cse_pkg::qmul_s(cp_q, scv2_q);
      o2b_q <= o2_q;
      o5_q  <= nbp_q;
      o8b_q <= o8_q;
    end
  end

  // stage 4: every term and sum fits in 28 bits, so the 32-bit results cannot overflow
  cse_pkg::result_t res_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_q.pos_x <= 32'(o0_q);
      res_q.pos_y <= 32'(o1_q);
      res_q.pos_z <= 32'(o2b_q);
      res_q.du_x  <= 32'(o3_q);
      res_q.du_y  <= 32'(o4_q);
      res_q.du_z  <= 32'(o5_q);
      res_q.dv_x  <= 32'(t1_q) + 32'(t2_q) + 32'(t3_q);
      res_q.dv_y  <= 32'(t4_q) - 32'(t5_q) - 32'(t6_q);
      res_q.dv_z  <= 32'(o8b_q);
    end
  end

  assign res_o = res_q;
endmodule
`default_nettype wire

// ===== hdl/crescent_surface_evaluator.sv =====
// Crescent surface evaluator top level: config registers, three sin/cos lanes, output skid.
// Path from input transaction to output valid: sin/cos lanes, the combine pipeline, output register.
// Throughput: one (u, v) pair per cycle while s_axis_tready is high; set by the CORDIC cell rows, one cell per stage.
// The whole pipeline holds only when both the output register and the skid stage are full.
// Reset (rst_ni low, asynchronous): pipeline and output empty, a = 1.5, b = 0.5, c = 1.0.
`default_nettype none
module crescent_surface_evaluator #(
  parameter int CORDIC_STAGES = cse_pkg::CordicStagesDef
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         cfg_we_i,
  input  wire logic [1:0]   cfg_idx_i,
  input  wire logic [15:0]  cfg_data_i,
  input  wire logic         s_axis_tvalid,
  output      logic         s_axis_tready,
  input  wire logic [31:0]  s_axis_tdata,  // u_param[15:0], v_param[31:16]
  output      logic         m_axis_tvalid,
  input  wire logic         m_axis_tready,
  output      logic [287:0] m_axis_tdata   // pos_x, pos_y, pos_z, du_x, du_y, du_z,
                                           // dv_x, dv_y, dv_z: 32 bits each, from bit 0
);
  localparam int LaneLat = CORDIC_STAGES + 7;
  localparam int Depth   = LaneLat + 4;

  logic signed [15:0] scale_a_q, freq_b_q, freq_c_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_a_q <= cse_pkg::ScaleAReset;
      freq_b_q  <= cse_pkg::FreqBReset;
      freq_c_q  <= cse_pkg::FreqCReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        cse_pkg::RegScaleA: scale_a_q <= cfg_data_i;
        cse_pkg::RegFreqB:  freq_b_q  <= cfg_data_i;
        cse_pkg::RegFreqC:  freq_c_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic en, accept;
  logic skid_v_q, out_v_q;
  cse_pkg::result_t res, skid_q, out_q;

  assign en            = !skid_v_q;
  assign s_axis_tready = en;
  assign accept        = s_axis_tvalid && en;

  logic [15:0] u_in, v_in;
  assign u_in = s_axis_tdata[15:0];
  assign v_in = s_axis_tdata[31:16];

  logic signed [17:0] sbu, cbu, sbv, cbv, scv, ccv;

  cse_sincos_lane #(.CordicStages(CORDIC_STAGES)) u_lane_bu (
    .clk_i, .en_i(en), .factor_i(freq_b_q), .param_i(u_in), .sin_o(sbu), .cos_o(cbu)
  );
  cse_sincos_lane #(.CordicStages(CORDIC_STAGES)) u_lane_bv (
    .clk_i, .en_i(en), .factor_i(freq_b_q), .param_i(v_in), .sin_o(sbv), .cos_o(cbv)
  );
  cse_sincos_lane #(.CordicStages(CORDIC_STAGES)) u_lane_cv (
    .clk_i, .en_i(en), .factor_i(freq_c_q), .param_i(v_in), .sin_o(scv), .cos_o(ccv)
  );

  // v rides alongside the lanes for the 4v/pi term
  logic [15:0] v_dly_q [LaneLat];
  always_ff @(posedge clk_i) begin
    if (en) begin
      v_dly_q[0] <= v_in;
      for (int i = 1; i < LaneLat; i++) v_dly_q[i] <= v_dly_q[i-1];
    end
  end

  cse_combine u_combine (
    .clk_i, .en_i(en),
    .scale_a_i(scale_a_q), .freq_b_i(freq_b_q), .freq_c_i(freq_c_q),
    .v_i(v_dly_q[LaneLat-1]),
    .sbu_i(sbu), .cbu_i(cbu), .sbv_i(sbv), .cbv_i(cbv), .scv_i(scv), .ccv_i(ccv),
    .res_o(res)
  );

  logic [Depth-1:0] vld_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= '0;
    else if (en) vld_q <= {vld_q[Depth-2:0], accept};
  end

  // output register with a skid stage behind it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (!out_v_q || m_axis_tready) begin
      out_v_q  <= skid_v_q || vld_q[Depth-1];
      skid_v_q <= 1'b0;
    end else if (vld_q[Depth-1] && en) begin
      skid_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_v_q || m_axis_tready) out_q <= skid_v_q ? skid_q : res;
    else if (en) skid_q <= res;
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {out_q.dv_z, out_q.dv_y, out_q.dv_x, out_q.du_z, out_q.du_y,
                          out_q.du_x, out_q.pos_z, out_q.pos_y, out_q.pos_x};
endmodule
`default_nettype wire

// ===== hdl/cse_checker.sv =====
// Port-level checker for the crescent surface evaluator, with its bind.
`default_nettype none
module cse_checker (
  input wire logic         clk_i,
  input wire logic         rst_ni,
  input wire logic         s_axis_tvalid,
  input wire logic         s_axis_tready,
  input wire logic         m_axis_tvalid,
  input wire logic         m_axis_tready,
  input wire logic [287:0] m_axis_tdata
);
  // with nothing shown at the output, the skid is empty and input is open
  a_idle_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready) else $error("input stalled with empty output");

  // an output transaction always frees the input side next cycle
  a_take_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tready) |=> s_axis_tready)
    else $error("input not ready after output transaction");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled result changed");

  // nothing can come out right after reset release
  a_reset_empty: assert property (@(posedge clk_i)
    !rst_ni |=> !m_axis_tvalid) else $error("output valid straight after reset");
endmodule

bind crescent_surface_evaluator cse_checker u_cse_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire
